/* rtl/dask_pkg.sv */
// ============================================================================
// dask_pkg
// Shared types, widths and helpers of the dual-axis scalar Kalman filter.
// ============================================================================
package dask_pkg;

    // Default number of fraction bits of the stored angles.
    localparam int DEF_STATE_FRAC_BITS = 22;

    // Gain format: unsigned Q1.24, with one integer bit so that 1.0 fits.
    localparam int KFRAC = 24;
    localparam int KW    = KFRAC + 1;
    localparam logic [KW-1:0] KONE = KW'(1) << KFRAC;

    // Divider widths: P + R needs one bit above P.
    localparam int COV_W   = 32;
    localparam int DEN_W   = COV_W + 1;
    localparam int DCNT_W  = $clog2(KW);

    // Shared multiplier: signed 20 x signed 26.
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // The innovation is split into two 19-bit halves for the multiplier.
    localparam int SPLIT_W   = 19;
    localparam int INNOV_X_W = 2 * SPLIT_W;

    // Covariance is split into two 16-bit halves for the multiplier.
    localparam int COV_SPLIT = 16;

    // Wide working sums.
    localparam int SUM_W = 44;
    localparam int ACC_W = 64;
    localparam logic signed [ACC_W-1:0] CORR_RND = ACC_W'(1) << (KFRAC - 1);

    // Reset values of state and registers.
    localparam logic [COV_W-1:0] COVAR_RESET = 32'd1677722;
    localparam logic [23:0]      Q_RESET     = 24'd16777;
    localparam logic [23:0]      R_RESET     = 24'd838861;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_Q_ROLL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_ROLL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_PITCH = 2'd3;

    // Axis select.
    localparam logic AXIS_ROLL  = 1'b0;
    localparam logic AXIS_PITCH = 1'b1;

    // Status of the gain divider.
    typedef struct packed {
        logic busy;
        logic done;
    } dask_div_stat_t;

    // Saturate a wide signed sum to the 32-bit signed range.
    function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
        logic [SUM_W-32:0] upper;
        upper = v[SUM_W-1:31];
        if ((&upper) || !(|upper))
            return v[31:0];
        else if (v[SUM_W-1])
            return 32'h8000_0000;
        else
            return 32'h7fff_ffff;
    endfunction

endpackage

/* rtl/dual_axis_scalar_kalman.sv */
// ============================================================================
// dual_axis_scalar_kalman
// The shared 25-step gain divider runs once per axis and the shared
// multiplier is used five times per axis. A new item is taken only in
// S_IDLE, once both axes are done and the result has been loaded out
// of S_PUBLISH; a stalled output keeps the block busy.
// Reset: asynchronous, active low; angles clear, covariances go to 0.1.
// ============================================================================
module dual_axis_scalar_kalman
    import dask_pkg::*;
#(
    parameter int STATE_FRAC_BITS = DEF_STATE_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [23:0]           cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    meas_roll,
    input  logic signed [15:0]    meas_pitch,
    input  logic signed [15:0]    rate_roll,
    input  logic signed [15:0]    rate_pitch,
    input  logic [15:0]           time_step,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    est_roll,
    output logic signed [15:0]    est_pitch,
    output logic signed [15:0]    pred_roll,
    output logic signed [15:0]    pred_pitch
);

    // The rate times time step product has 20 fraction bits; it is moved to
    // the state format by a left shift or a floor right shift.
    localparam int LSH      = (STATE_FRAC_BITS >= 20) ? STATE_FRAC_BITS - 20 : 0;
    localparam int RSH      = (STATE_FRAC_BITS >= 20) ? 0 : 20 - STATE_FRAC_BITS;
    localparam int MEAS_SH  = STATE_FRAC_BITS - 7;
    localparam int Q97_SH   = STATE_FRAC_BITS - 7;
    localparam logic signed [32:0] Q97_RND = 33'sd1 <<< (STATE_FRAC_BITS - 8);

    // Sequencer states. Each axis walks from S_RATE_MUL to S_COV_DONE.
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_RATE_MUL   = 4'd1;
    localparam logic [3:0] S_PREDICT    = 4'd2;
    localparam logic [3:0] S_DIV_SETUP  = 4'd3;
    localparam logic [3:0] S_DIVIDE     = 4'd4;
    localparam logic [3:0] S_INNOV_LO   = 4'd5;
    localparam logic [3:0] S_INNOV_HI   = 4'd6;
    localparam logic [3:0] S_CORR_SUM   = 4'd7;
    localparam logic [3:0] S_CORR_ROUND = 4'd8;
    localparam logic [3:0] S_CORRECT    = 4'd9;
    localparam logic [3:0] S_COV_HI     = 4'd10;
    localparam logic [3:0] S_COV_SUM    = 4'd11;
    localparam logic [3:0] S_COV_DONE   = 4'd12;
    localparam logic [3:0] S_PUBLISH    = 4'd13;

    // Round half up to Q9.7 and saturate to 16 bits.
    function automatic logic signed [15:0] to_q97(input logic signed [31:0] a);
        logic signed [32:0] v;
        v = {a[31], a};
        v = v + Q97_RND;
        v = v >>> Q97_SH;
        if (v > 33'sd32767)
            return 16'sh7fff;
        else if (v < -33'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Control and filter state.
    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic                      axis_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        angle_reg [2];
    logic [COV_W-1:0]          covar_reg [2];
    logic [23:0]               q_reg     [2];
    logic [23:0]               r_reg     [2];

    // Captured item and per-item working registers.
    logic signed [15:0]        meas_roll_reg;
    logic signed [15:0]        meas_pitch_reg;
    logic signed [15:0]        rate_roll_reg;
    logic signed [15:0]        rate_pitch_reg;
    logic [15:0]               time_step_reg;
    logic signed [PROD_W-1:0]  mul_reg;
    logic signed [31:0]        ang_work_reg;
    logic [COV_W-1:0]          p_work_reg;
    logic signed [INNOV_X_W-1:0] innov_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [15:0]        pred_res_reg [2];
    logic signed [15:0]        est_res_reg  [2];
    logic signed [15:0]        est_roll_reg;
    logic signed [15:0]        est_pitch_reg;
    logic signed [15:0]        pred_roll_reg;
    logic signed [15:0]        pred_pitch_reg;

    // Combinational helpers.
    logic signed [15:0]        meas_sel;
    logic signed [15:0]        rate_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [SUM_W-1:0]   delta_w;
    logic signed [SUM_W-1:0]   pred_sum;
    logic signed [SUM_W-1:0]   corr_sum;
    logic [COV_W:0]            p_sum;
    logic [DEN_W-1:0]          den_w;
    logic signed [INNOV_X_W-1:0] meas_w;
    logic signed [INNOV_X_W-1:0] innov_w;
    logic [KW-1:0]             k_w;
    logic [KW-1:0]             km_w;
    logic                      accept;
    logic                      load_out;
    logic                      div_start;
    dask_div_stat_t            div_stat;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign load_out  = (state_reg == S_PUBLISH) && (!out_valid_reg || !out_stall);
    assign div_start = (state_reg == S_DIV_SETUP);

    assign meas_sel = (axis_reg == AXIS_PITCH) ? meas_pitch_reg : meas_roll_reg;
    assign rate_sel = (axis_reg == AXIS_PITCH) ? rate_pitch_reg : rate_roll_reg;

    // The gain divider computes K = (P << 24) / (P + R), zero when P + R is
    // zero. It holds its quotient until the next start.
    assign den_w = {1'b0, p_work_reg} + {{(DEN_W-24){1'b0}}, r_reg[axis_reg]};

    dask_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_work_reg),
        .den   (den_w),
        .stat  (div_stat),
        .quot  (k_w)
    );

    assign km_w = KONE - k_w;

    // Operand selection for the one shared multiplier. Its product is
    // registered and used by the following state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RATE_MUL:
            begin
                mul_a = {{(MUL_A_W-16){rate_sel[15]}}, rate_sel};
                mul_b = {{(MUL_B_W-16){1'b0}}, time_step_reg};
            end
            S_INNOV_LO:
            begin
                mul_a = {1'b0, innov_reg[SPLIT_W-1:0]};
                mul_b = {1'b0, k_w};
            end
            S_INNOV_HI:
            begin
                mul_a = {innov_reg[INNOV_X_W-1], innov_reg[INNOV_X_W-1:SPLIT_W]};
                mul_b = {1'b0, k_w};
            end
            S_CORRECT:
            begin
                mul_a = {{(MUL_A_W-COV_SPLIT){1'b0}}, p_work_reg[COV_SPLIT-1:0]};
                mul_b = {1'b0, km_w};
            end
            S_COV_HI:
            begin
                mul_a = {{(MUL_A_W-COV_SPLIT){1'b0}}, p_work_reg[COV_W-1:COV_SPLIT]};
                mul_b = {1'b0, km_w};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Prediction, covariance growth, innovation and correction sums.
    always_comb
    begin
        delta_w  = {{(SUM_W-32){mul_reg[31]}}, mul_reg[31:0]};
        delta_w  = delta_w <<< LSH;
        delta_w  = delta_w >>> RSH;
        pred_sum = {{(SUM_W-32){angle_reg[axis_reg][31]}}, angle_reg[axis_reg]} + delta_w;
        corr_sum = {{(SUM_W-32){ang_work_reg[31]}}, ang_work_reg} + acc_reg[SUM_W-1:0];
        p_sum    = {1'b0, covar_reg[axis_reg]} + {{(COV_W-23){1'b0}}, q_reg[axis_reg]};
        meas_w   = {{(INNOV_X_W-16){meas_sel[15]}}, meas_sel};
        meas_w   = meas_w <<< MEAS_SH;
        innov_w  = meas_w - {{(INNOV_X_W-32){ang_work_reg[31]}}, ang_work_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_RATE_MUL;
            S_RATE_MUL:   state_next = S_PREDICT;
            S_PREDICT:    state_next = S_DIV_SETUP;
            S_DIV_SETUP:  state_next = S_DIVIDE;
            S_DIVIDE:     if (div_stat.done) state_next = S_INNOV_LO;
            S_INNOV_LO:   state_next = S_INNOV_HI;
            S_INNOV_HI:   state_next = S_CORR_SUM;
            S_CORR_SUM:   state_next = S_CORR_ROUND;
            S_CORR_ROUND: state_next = S_CORRECT;
            S_CORRECT:    state_next = S_COV_HI;
            S_COV_HI:     state_next = S_COV_SUM;
            S_COV_SUM:    state_next = S_COV_DONE;
            S_COV_DONE:   state_next = (axis_reg == AXIS_ROLL) ? S_RATE_MUL : S_PUBLISH;
            S_PUBLISH:    if (load_out) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Control state, filter state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_ROLL;
            out_valid_reg <= 1'b0;
            angle_reg[0]  <= '0;
            angle_reg[1]  <= '0;
            covar_reg[0]  <= COVAR_RESET;
            covar_reg[1]  <= COVAR_RESET;
            q_reg[0]      <= Q_RESET;
            q_reg[1]      <= Q_RESET;
            r_reg[0]      <= R_RESET;
            r_reg[1]      <= R_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_Q_ROLL:  q_reg[AXIS_ROLL]  <= cfg_data;
                    REG_Q_PITCH: q_reg[AXIS_PITCH] <= cfg_data;
                    REG_R_ROLL:  r_reg[AXIS_ROLL]  <= cfg_data;
                    REG_R_PITCH: r_reg[AXIS_PITCH] <= cfg_data;
                    default:     ;
                endcase
            end

            if (accept)
                axis_reg <= AXIS_ROLL;
            else if (state_reg == S_COV_DONE)
                axis_reg <= AXIS_PITCH;

            // The new covariance is ((1 - K) * P) >> 24, never above P.
            if (state_reg == S_COV_DONE)
            begin
                angle_reg[axis_reg] <= ang_work_reg;
                covar_reg[axis_reg] <= acc_reg[KFRAC +: COV_W];
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;

        if (accept)
        begin
            meas_roll_reg  <= meas_roll;
            meas_pitch_reg <= meas_pitch;
            rate_roll_reg  <= rate_roll;
            rate_pitch_reg <= rate_pitch;
            time_step_reg  <= time_step;
        end

        case (state_reg)
            S_PREDICT:
            begin
                ang_work_reg <= sat32(pred_sum);
                p_work_reg   <= p_sum[COV_W] ? {COV_W{1'b1}} : p_sum[COV_W-1:0];
            end
            S_DIV_SETUP:
            begin
                pred_res_reg[axis_reg] <= to_q97(ang_work_reg);
                innov_reg              <= innov_w;
            end
            S_INNOV_HI:
            begin
                acc_reg <= {{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg};
            end
            S_CORR_SUM:
            begin
                acc_reg <= acc_reg +
                    ({{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg} <<< SPLIT_W);
            end
            S_CORR_ROUND:
            begin
                acc_reg <= (acc_reg + CORR_RND) >>> KFRAC;
            end
            S_CORRECT:
            begin
                ang_work_reg <= sat32(corr_sum);
            end
            S_COV_HI:
            begin
                est_res_reg[axis_reg] <= to_q97(ang_work_reg);
                acc_reg <= {{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg};
            end
            S_COV_SUM:
            begin
                acc_reg <= acc_reg +
                    ({{(ACC_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg} <<< COV_SPLIT);
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            est_roll_reg   <= est_res_reg[AXIS_ROLL];
            est_pitch_reg  <= est_res_reg[AXIS_PITCH];
            pred_roll_reg  <= pred_res_reg[AXIS_ROLL];
            pred_pitch_reg <= pred_res_reg[AXIS_PITCH];
        end
    end

    assign out_valid  = out_valid_reg;
    assign est_roll   = est_roll_reg;
    assign est_pitch  = est_pitch_reg;
    assign pred_roll  = pred_roll_reg;
    assign pred_pitch = pred_pitch_reg;

endmodule

/* rtl/dask_div.sv */
// ============================================================================
// dask_div
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// ============================================================================
module dask_div
    import dask_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [COV_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output dask_div_stat_t       stat,
    output logic [KW-1:0]        quot
);

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                lsb_reg;
    logic                den_zero_reg;
    logic [KW-1:0]       quot_reg;

    logic [DEN_W:0]      trial;
    logic [DEN_W+1:0]    diff;
    logic                fits;

    // The dividend is num shifted up by KFRAC; only the lowest bit of num
    // enters after the initial remainder of num / 2.
    always_comb
    begin
        trial = {rem_reg, (cnt_reg == DCNT_W'(KW - 1)) ? lsb_reg : 1'b0};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        fits  = !diff[DEN_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(KW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= {2'b00, num[COV_W-1:1]};
            lsb_reg      <= num[0];
            den_reg      <= den;
            den_zero_reg <= (den == '0);
            quot_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[KW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = den_zero_reg ? '0 : quot_reg;

endmodule

/* rtl/dask_checker.sv */
// ============================================================================
// dask_checker
// Port-level checks of the Kalman filter block, bound to the top level.
// ============================================================================
module dask_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] est_roll,
    input logic [15:0] est_pitch,
    input logic [15:0] pred_roll,
    input logic [15:0] pred_pitch
);

    // An accepted item keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was accepted");

    // An accepted item keeps the block busy while its axes are worked through.
    a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##40 in_stall)
        else $error("block became ready too early");

    // A new result only comes out of a busy block.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(est_roll) &&
            $stable(est_pitch) && $stable(pred_roll) && $stable(pred_pitch))
        else $error("stalled result changed");

endmodule

bind dual_axis_scalar_kalman dask_checker u_dask_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .est_roll   (est_roll),
    .est_pitch  (est_pitch),
    .pred_roll  (pred_roll),
    .pred_pitch (pred_pitch)
);

/* bench/dual_axis_scalar_kalman_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// dual_axis_scalar_kalman_tb
// Self-checking bench for the two-axis gyro/tilt Kalman filter. A queue of IMU
// samples feeds a clocked driver, and a clocked monitor predicts the filtered
// and gyro-only angles of every accepted sample and compares them, field by
// field, with the results in arrival order. The run steps through several
// noise settings, from zero to full scale, with and without random gaps.
// ============================================================================
module dual_axis_scalar_kalman_tb;
    import dask_pkg::*;

    localparam int FRAC          = DEF_STATE_FRAC_BITS;
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 100;    // a little more than one item's latency
    localparam int MAX_PRINTED   = 40;
    localparam logic [23:0] NOISE_MAX = 24'hFF_FFFF;
    localparam logic [63:0] GAIN_ONE  = 64'd1 << KFRAC;

    // One IMU sample, as it is presented on the input channel.
    typedef struct packed {
        logic signed [15:0] meas_roll;
        logic signed [15:0] meas_pitch;
        logic signed [15:0] rate_roll;
        logic signed [15:0] rate_pitch;
        logic        [15:0] time_step;
    } imu_item_t;

    // One filter result, as it leaves on the output channel.
    typedef struct packed {
        logic signed [15:0] est_roll;
        logic signed [15:0] est_pitch;
        logic signed [15:0] pred_roll;
        logic signed [15:0] pred_pitch;
    } attitude_t;

    // ------------------------------------------------------------------------
    // Block under test. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = REG_Q_ROLL;
    logic [23:0]          cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic signed [15:0]   meas_roll  = '0;
    logic signed [15:0]   meas_pitch = '0;
    logic signed [15:0]   rate_roll  = '0;
    logic signed [15:0]   rate_pitch = '0;
    logic        [15:0]   time_step  = '0;
    logic                 out_stall  = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic signed [15:0]   est_roll;
    logic signed [15:0]   est_pitch;
    logic signed [15:0]   pred_roll;
    logic signed [15:0]   pred_pitch;

    dual_axis_scalar_kalman #(
        .STATE_FRAC_BITS (FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .meas_roll  (meas_roll),
        .meas_pitch (meas_pitch),
        .rate_roll  (rate_roll),
        .rate_pitch (rate_pitch),
        .time_step  (time_step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .est_roll   (est_roll),
        .est_pitch  (est_pitch),
        .pred_roll  (pred_roll),
        .pred_pitch (pred_pitch)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench state. The filter's own state is mirrored per axis, indexed by
    // the package's axis select constants.
    // ------------------------------------------------------------------------
    logic signed [31:0] angle_track [2];
    logic        [31:0] covar_track [2];
    logic        [23:0] q_noise     [2];
    logic        [23:0] r_noise     [2];

    imu_item_t pending_items [$];    // samples not yet offered to the block
    attitude_t expected_att  [$];    // predicted results, oldest first
    imu_item_t next_item;
    imu_item_t seen_item;

    int  send_gap_pct   = 9;         // chance per cycle that the sender idles
    int  recv_stall_pct = 49;        // chance per cycle that the receiver stalls
    bit  item_taken     = 1'b0;      // input handshake at the last rising edge
    bit  result_taken   = 1'b0;
    int  quiet_cycles   = 0;
    int  items_sent     = 0;
    int  results_checked = 0;
    int  noise_settings = 0;
    int  saturated_seen = 0;
    int  mismatches     = 0;

    // ------------------------------------------------------------------------
    // Fixed-point helpers of the predictor.
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clamp_angle(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Round half up to 7 fraction bits, then saturate to a signed Q9.7 word.
    function automatic logic signed [15:0] angle_to_q97(input logic signed [31:0] a);
        logic signed [63:0] w;
        w = a;
        w = (w + (64'sd1 <<< (FRAC - 8))) >>> (FRAC - 7);
        if (w > 64'sd32767)
            return 16'h7fff;
        if (w < -64'sd32768)
            return 16'h8000;
        return w[15:0];
    endfunction

    // One axis of the filter: gyro prediction, gain, correction and the new
    // covariance. The axis state in angle_track and covar_track is updated.
    function automatic void filter_axis(input logic ax,
                                        input logic signed [15:0] meas,
                                        input logic signed [15:0] rate,
                                        input logic [15:0] dt,
                                        output logic signed [15:0] est,
                                        output logic signed [15:0] pred);
        logic signed [63:0] rate_w;
        logic signed [63:0] dt_w;
        logic signed [63:0] meas_w;
        logic signed [63:0] step;
        logic signed [63:0] ang;
        logic signed [63:0] innov;
        logic signed [63:0] gain_s;
        logic signed [63:0] corr;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] new_cov;
        int sh;
        rate_w = rate;
        dt_w   = {48'd0, dt};
        meas_w = meas;

        // rate * dt carries 20 fraction bits; bring it to the state format.
        step = rate_w * dt_w;
        sh = FRAC - 20;
        if (sh >= 0)
            step = step <<< sh;
        else
            step = step >>> (-sh);
        ang = angle_track[ax];
        angle_track[ax] = clamp_angle(ang + step);
        pred = angle_to_q97(angle_track[ax]);

        // Covariance grows by Q and saturates at the top of 32 bits.
        p = {32'd0, covar_track[ax]} + {40'd0, q_noise[ax]};
        if (p > 64'h0000_0000_ffff_ffff)
            p = 64'h0000_0000_ffff_ffff;

        // Gain K = P / (P + R), with K = 0 when both are zero.
        den  = p + {40'd0, r_noise[ax]};
        gain = (den == 64'd0) ? 64'd0 : (p << KFRAC) / den;
        if (gain > GAIN_ONE)
            gain = GAIN_ONE;
        gain_s = gain;

        ang   = angle_track[ax];
        innov = (meas_w <<< (FRAC - 7)) - ang;
        corr  = (innov * gain_s + (64'sd1 <<< (KFRAC - 1))) >>> KFRAC;
        angle_track[ax] = clamp_angle(ang + corr);
        est = angle_to_q97(angle_track[ax]);

        new_cov = ((GAIN_ONE - gain) * p) >> KFRAC;
        covar_track[ax] = new_cov[31:0];
    endfunction

    function automatic attitude_t kalman_update(input imu_item_t s);
        attitude_t r;
        filter_axis(AXIS_ROLL, s.meas_roll, s.rate_roll, s.time_step,
                    r.est_roll, r.pred_roll);
        filter_axis(AXIS_PITCH, s.meas_pitch, s.rate_pitch, s.time_step,
                    r.est_pitch, r.pred_pitch);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [15:0] got,
                               input logic signed [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                      results_checked, name, got, want));
        if (want == 16'sh7fff || want == -16'sh8000)
            saturated_seen++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic imu_item_t imu_sample(input int mr, input int mp, input int rr,
                                             input int rp, input int dt);
        imu_item_t s;
        s.meas_roll  = mr[15:0];
        s.meas_pitch = mp[15:0];
        s.rate_roll  = rr[15:0];
        s.rate_pitch = rp[15:0];
        s.time_step  = dt[15:0];
        return s;
    endfunction

    function automatic logic [15:0] span(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(hi - lo));
        return v[15:0];
    endfunction

    // Most samples look like a vehicle in flight: moderate rates, sample
    // periods from tens of microseconds to tens of milliseconds and tilt
    // readings within +-90 degrees. The rest are zero time steps and
    // samples with every field drawn over its full range.
    function automatic imu_item_t random_sample();
        imu_item_t s;
        int unsigned sel;
        sel = $urandom_range(99);
        s.meas_roll  = 16'($urandom);
        s.meas_pitch = 16'($urandom);
        s.rate_roll  = 16'($urandom);
        s.rate_pitch = 16'($urandom);
        s.time_step  = 16'($urandom);
        if (sel < 70) begin
            s.meas_roll  = span(-11520, 11520);
            s.meas_pitch = span(-11520, 11520);
            s.rate_roll  = span(-3200, 3200);
            s.rate_pitch = span(-3200, 3200);
            s.time_step  = span(1, 2000);
        end else if (sel < 76) begin
            s.time_step = '0;
        end
        return s;
    endfunction

    // Returns once every queued sample has been taken and every predicted
    // result has come back, so the block is idle.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_att.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_noise(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_Q_ROLL:  q_noise[AXIS_ROLL]  = val;
            REG_Q_PITCH: q_noise[AXIS_PITCH] = val;
            REG_R_ROLL:  r_noise[AXIS_ROLL]  = val;
            REG_R_PITCH: r_noise[AXIS_PITCH] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_noise(input logic [23:0] qr, input logic [23:0] qp,
                             input logic [23:0] rr, input logic [23:0] rp);
        write_noise(REG_Q_ROLL,  qr);
        write_noise(REG_Q_PITCH, qp);
        write_noise(REG_R_ROLL,  rr);
        write_noise(REG_R_PITCH, rp);
        noise_settings++;
    endtask

    // One noise setting with random samples. Halfway through, the sender
    // holds off until the block has drained completely.
    task automatic noise_phase(input logic [23:0] qr, input logic [23:0] qp,
                               input logic [23:0] rr, input logic [23:0] rp,
                               input int count);
        set_noise(qr, qp, rr, rp);
        repeat (count / 2) pending_items.push_back(random_sample());
        wait_idle();
        repeat (count - count / 2) pending_items.push_back(random_sample());
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A new sample is loaded only
    // when the channel is empty or the current one was taken at the last
    // rising edge, so a stalled sample stays put. The idle decision never
    // looks at in_stall.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            if (!in_valid || item_taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_item   = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    meas_roll  <= next_item.meas_roll;
                    meas_pitch <= next_item.meas_pitch;
                    rate_roll  <= next_item.rate_roll;
                    rate_pitch <= next_item.rate_pitch;
                    time_step  <= next_item.time_step;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog: everything is sampled on the rising edge. The
    // outgoing result is checked before the incoming item is predicted, so
    // a result that arrives with nothing pending is never matched against
    // the item taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            item_taken   = in_valid && !in_stall;
            result_taken = out_valid && !out_stall;

            if (result_taken) begin
                if (expected_att.size() == 0) begin
                    report_mismatch("result arrived with no item outstanding");
                end else begin
                    attitude_t want;
                    want = expected_att.pop_front();
                    check_field("est_roll",   est_roll,   want.est_roll);
                    check_field("est_pitch",  est_pitch,  want.est_pitch);
                    check_field("pred_roll",  pred_roll,  want.pred_roll);
                    check_field("pred_pitch", pred_pitch, want.pred_pitch);
                end
                results_checked++;
            end

            if (item_taken) begin
                seen_item.meas_roll  = meas_roll;
                seen_item.meas_pitch = meas_pitch;
                seen_item.rate_roll  = rate_roll;
                seen_item.rate_pitch = rate_pitch;
                seen_item.time_step  = time_step;
                expected_att.push_back(kalman_update(seen_item));
                items_sent++;
            end

            if (item_taken || result_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns  watchdog: no handshake for %0d cycles, %0d results owed",
                         $time, quiet_cycles, expected_att.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        angle_track[AXIS_ROLL]  = '0;
        angle_track[AXIS_PITCH] = '0;
        covar_track[AXIS_ROLL]  = COVAR_RESET;
        covar_track[AXIS_PITCH] = COVAR_RESET;
        q_noise[AXIS_ROLL]      = Q_RESET;
        q_noise[AXIS_PITCH]     = Q_RESET;
        r_noise[AXIS_ROLL]      = R_RESET;
        r_noise[AXIS_PITCH]     = R_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed samples on the reset noise values. A zero time step must
        // leave the angle alone; full-scale rates over a full-scale time
        // step drive the state angle into saturation, first up on roll and
        // down on pitch, then the other way round.
        pending_items.push_back(imu_sample(0, 0, 0, 0, 0));
        pending_items.push_back(imu_sample(32767, -32768, 0, 0, 0));
        pending_items.push_back(imu_sample(-32768, 32767, 0, 0, 65535));
        repeat (3) pending_items.push_back(imu_sample(32767, -32768, 32767, -32768, 65535));
        repeat (3) pending_items.push_back(imu_sample(-32768, 32767, -32768, 32767, 65535));
        pending_items.push_back(imu_sample(0, 0, 1, -1, 1));
        pending_items.push_back(imu_sample(128, -128, 16, -16, 655));
        pending_items.push_back(imu_sample(-21846, 21845, -21846, 21845, 43690));
        pending_items.push_back(imu_sample(21845, -21846, 21845, -21846, 21845));
        pending_items.push_back(imu_sample(0, 0, 32767, 32767, 1));
        pending_items.push_back(imu_sample(1, -1, -1, -1, 65535));
        wait_idle();

        // Zero process and measurement noise. The first sample still has
        // covariance left, so the gain is exactly one and the estimate
        // snaps to the measurement; that empties the covariance, and from
        // then on P + R is zero, the gain is zero and the estimate follows
        // the gyro alone.
        set_noise('0, '0, '0, '0);
        pending_items.push_back(imu_sample(1280, -1280, 100, -100, 1000));
        pending_items.push_back(imu_sample(2560, -2560, 0, 0, 0));
        pending_items.push_back(imu_sample(-32768, 32767, 32767, -32768, 65535));
        pending_items.push_back(imu_sample(500, 600, 0, 0, 100));
        pending_items.push_back(imu_sample(0, 0, 0, 0, 0));
        wait_idle();

        // Random part. Full-scale noise first, with a slow receiver.
        noise_phase(NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX, 160);

        // Slow sender, quick receiver: a lopsided setting where one axis trusts
        // the gyro and the other the measurement, then a random setting.
        send_gap_pct   = 49;
        recv_stall_pct = 9;
        noise_phase('0, NOISE_MAX, 24'd1, NOISE_MAX, 160);
        noise_phase(24'($urandom_range(NOISE_MAX)), 24'($urandom_range(NOISE_MAX)),
                    24'($urandom_range(NOISE_MAX, 1)), 24'($urandom_range(NOISE_MAX, 1)),
                    160);

        // Back to back in both directions.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        noise_phase(24'd1, '0, NOISE_MAX, 24'd1, 160);
        noise_phase(24'($urandom_range(4095)), 24'($urandom_range(NOISE_MAX)),
                    24'($urandom_range(4095, 1)), 24'($urandom_range(NOISE_MAX, 1)),
                    160);
        noise_phase(Q_RESET, Q_RESET, R_RESET, R_RESET, 160);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_att.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_att.size()));

        $display("Run covered %0d samples and %0d results under %0d noise settings,",
                 items_sent, results_checked, noise_settings);
        $display("with %0d saturated output fields and %0d mismatches.",
                 saturated_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* dual_axis_scalar_kalman.f */
rtl/dask_pkg.sv
rtl/dask_div.sv
rtl/dual_axis_scalar_kalman.sv
rtl/dask_checker.sv
bench/dual_axis_scalar_kalman_tb.sv
